FILE: sv/irlc_pkg.sv
// Package for the IR remote learning controller: constants, widths, command structs.
// No dependencies.
`timescale 1ns / 1ps
package irlc_pkg;
  localparam int SampleDepth = 20;
  localparam int SampleIdxW = $clog2(SampleDepth);
  localparam int CountW = $clog2(SampleDepth + 1);
  localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;
  localparam logic [5:0] RelayMask = 6'h3F;

  localparam logic [2:0] CfgVolFloor = 3'd0;
  localparam logic [2:0] CfgVolCeil = 3'd1;
  localparam logic [2:0] CfgInpFloor = 3'd2;
  localparam logic [2:0] CfgInpCeil = 3'd3;
  localparam logic [2:0] CfgLongPress = 3'd4;
  localparam logic [2:0] CfgTimeout = 3'd5;

  localparam logic [2:0] ModeNormal = 3'd0;
  localparam logic [2:0] ModeRepeat = 3'd5;

  // controller -> datapath
  typedef struct packed {
    logic tick;         // run the per-tick update on the captured item
    logic clr_search;   // start of most-frequent search
    logic cmp_step;     // compare outer vs inner sample
    logic outer_end;    // close one outer entry
    logic finish;       // write the repeat code, settle learning
  } irlc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_search;  // last sample just stored
  } irlc_sts_t;
endpackage

FILE: sv/irlc_datapath.sv
// Datapath: registers, tick update, sample memory and most-frequent search.
// Depends on irlc_pkg.
`timescale 1ns / 1ps
module irlc_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [41:0]         item,
  input  irlc_pkg::irlc_cmd_t cmd,
  input  logic [irlc_pkg::SampleIdxW-1:0] idx_i,
  input  logic [irlc_pkg::SampleIdxW-1:0] idx_j,
  output irlc_pkg::irlc_sts_t sts,
  output logic [25:0]         result
);
  logic [5:0] vol_floor, vol_ceil, volume_reg;
  logic [3:0] inp_floor, inp_ceil, input_reg;
  logic [15:0] long_press, timeout, press_ticks, learn_timer;
  logic [2:0] mode;
  logic prev_button, press_active, mute_reg, done;
  logic [31:0] learned [5];
  logic [31:0] last_command;
  logic [irlc_pkg::CountW-1:0] sample_count;
  logic [31:0] store [irlc_pkg::SampleDepth];
  logic [31:0] rd_i, rd_j, best;
  logic [irlc_pkg::CountW-1:0] n, best_n;

  logic btn, irv;
  logic [31:0] code;
  logic signed [7:0] delta;
  assign btn = item[0];
  assign irv = item[1];
  assign code = item[33:2];
  assign delta = item[41:34];

  // combinational tick update
  logic [5:0] v1, v3;
  logic [3:0] i3;
  logic [2:0] m2, m3, m4;
  logic pa2, mu2, ent, st_wr, need;
  logic [15:0] pt2, lt2;
  logic signed [8:0] nv;
  logic [irlc_pkg::CountW-1:0] sc3;
  logic [31:0] lc3;
  logic [2:0] lw_idx;
  logic lw;
  always_comb begin
    nv = $signed({3'b0, volume_reg}) + 9'(delta);
    v1 = volume_reg;
    if (!mute_reg && delta != 8'sd0) begin
      if (nv < $signed({3'b0, vol_floor})) nv = $signed({3'b0, vol_floor});
      if (nv > $signed({3'b0, vol_ceil})) nv = $signed({3'b0, vol_ceil});
      v1 = nv[5:0];
    end
    pt2 = press_ticks;
    if (press_active && press_ticks != 16'hFFFF) pt2 = press_ticks + 16'd1;
    pa2 = press_active; m2 = mode; mu2 = mute_reg;
    if (btn != prev_button) begin
      if (btn) begin
        pa2 = 1'b1; pt2 = '0;
      end else begin
        if (press_active) begin
          if (mode != irlc_pkg::ModeNormal) m2 = irlc_pkg::ModeNormal;
          else if (pt2 < long_press) mu2 = ~mute_reg;
        end
        pa2 = 1'b0;
      end
    end
    ent = 1'b0; lt2 = learn_timer;
    if (btn && pa2 && m2 == irlc_pkg::ModeNormal && pt2 >= long_press) begin
      m2 = 3'd1; lt2 = timeout; pa2 = 1'b0; ent = 1'b1;
    end
    m3 = m2; v3 = v1; i3 = input_reg; sc3 = sample_count; lc3 = last_command;
    st_wr = 1'b0; need = 1'b0; lw = 1'b0; lw_idx = '0;
    if (irv) begin
      if (m2 != irlc_pkg::ModeNormal) begin
        if (code != 32'd0 && (m2 == irlc_pkg::ModeRepeat || code != irlc_pkg::AllOnes)) begin
          if (m2 >= 3'd1 && m2 <= 3'd4) begin
            lw = 1'b1; lw_idx = m2 - 3'd1;
            if (m2 == 3'd4) sc3 = '0;
            m3 = m2 + 3'd1;
          end else if (m2 == irlc_pkg::ModeRepeat &&
                       sample_count < irlc_pkg::CountW'(irlc_pkg::SampleDepth)) begin
            st_wr = 1'b1;
            sc3 = sample_count + 1'b1;
            if (sc3 == irlc_pkg::CountW'(irlc_pkg::SampleDepth)) need = 1'b1;
          end
        end
      end else if (code == learned[4] && learned[4] != 32'd0) begin
        if (last_command == learned[0]) begin
          if (v1 != 6'h3F && v1 + 6'd1 <= vol_ceil) v3 = v1 + 6'd1;
        end else if (last_command == learned[1]) begin
          if (v1 != 6'd0 && v1 - 6'd1 >= vol_floor) v3 = v1 - 6'd1;
        end
      end else if (code != 32'd0) begin
        if (code == learned[0]) begin
          if (v1 != 6'h3F && v1 + 6'd1 <= vol_ceil) v3 = v1 + 6'd1;
          lc3 = code;
        end else if (code == learned[1]) begin
          if (v1 != 6'd0 && v1 - 6'd1 >= vol_floor) v3 = v1 - 6'd1;
          lc3 = code;
        end else if (code == learned[2]) begin
          if (input_reg != 4'hF && input_reg + 4'd1 <= inp_ceil) i3 = input_reg + 4'd1;
          lc3 = code;
        end else if (code == learned[3]) begin
          if (input_reg != 4'd0 && input_reg - 4'd1 >= inp_floor) i3 = input_reg - 4'd1;
          lc3 = code;
        end
      end
    end
    // timeout; the search, if started, sees mode already past this
    m4 = m3;
    if (m3 != irlc_pkg::ModeNormal && !ent) begin
      if (lt2 == 16'd0) m4 = irlc_pkg::ModeNormal;
      else lt2 = lt2 - 16'd1;
    end
  end

  assign sts.need_search = need;

  always_ff @(posedge clk) begin
    if (cmd.tick && st_wr) store[sample_count[irlc_pkg::SampleIdxW-1:0]] <= code;
    rd_i <= store[idx_i];
    rd_j <= store[idx_j];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vol_floor <= 6'd0; vol_ceil <= 6'd63; inp_floor <= 4'd1; inp_ceil <= 4'd4;
      long_press <= 16'd1000; timeout <= 16'd30000;
      mode <= irlc_pkg::ModeNormal; prev_button <= 1'b0; press_active <= 1'b0;
      press_ticks <= '0; learn_timer <= '0;
      for (int k = 0; k < 5; k++) learned[k] <= '0;
      last_command <= '0; volume_reg <= 6'd0; input_reg <= 4'd1; mute_reg <= 1'b0;
      sample_count <= '0; done <= 1'b0; n <= '0; best_n <= '0; best <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          irlc_pkg::CfgVolFloor: vol_floor <= cfg_data[5:0];
          irlc_pkg::CfgVolCeil: vol_ceil <= cfg_data[5:0];
          irlc_pkg::CfgInpFloor: inp_floor <= cfg_data[3:0];
          irlc_pkg::CfgInpCeil: inp_ceil <= cfg_data[3:0];
          irlc_pkg::CfgLongPress: long_press <= cfg_data;
          irlc_pkg::CfgTimeout: timeout <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.tick) begin
        volume_reg <= v3; input_reg <= i3; mute_reg <= mu2;
        prev_button <= btn; press_active <= pa2; press_ticks <= pt2;
        learn_timer <= lt2; last_command <= lc3; sample_count <= sc3;
        mode <= need ? irlc_pkg::ModeRepeat : m4;
        if (lw) learned[lw_idx] <= code;
        done <= 1'b0;
      end
      if (cmd.clr_search) begin
        best_n <= '0; best <= '0; n <= '0;
      end
      if (cmd.cmp_step && rd_i == rd_j) n <= n + 1'b1;
      if (cmd.outer_end) begin
        if (n > best_n) begin
          best_n <= n; best <= rd_i;
        end
        n <= '0;
      end
      if (cmd.finish) begin
        learned[4] <= best; mode <= irlc_pkg::ModeNormal; done <= 1'b1;
      end
    end
  end

  assign result = {done, sample_count, mode, mute_reg ? 6'd0 : (volume_reg & irlc_pkg::RelayMask),
                   mute_reg, input_reg, volume_reg};
endmodule

FILE: sv/irlc_ctrl.sv
// Controller: item/result handshake and sequencing of the repeat-code search.
// Depends on irlc_pkg.
`timescale 1ns / 1ps
module irlc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic                out_fire,
  input  irlc_pkg::irlc_sts_t sts,
  output irlc_pkg::irlc_cmd_t cmd,
  output logic                in_rdy,
  output logic                out_vld,
  output logic [irlc_pkg::SampleIdxW-1:0] idx_i,
  output logic [irlc_pkg::SampleIdxW-1:0] idx_j
);
  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_CLR, S_CMP, S_LAND, S_OEND, S_FIN, S_OUT
  } state_t;
  state_t state;
  localparam logic [irlc_pkg::SampleIdxW-1:0] Last =
    irlc_pkg::SampleIdxW'(irlc_pkg::SampleDepth - 1);
  // a compare result lands in the cycle after its address pair, from the registered memory read
  logic cmp_pend, last_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; idx_i <= '0; idx_j <= '0; cmp_pend <= 1'b0; last_pend <= 1'b0;
    end else begin
      cmp_pend <= (state == S_CLR) || (state == S_CMP);
      case (state)
        S_IDLE: if (in_fire) state <= S_EXEC;
        S_EXEC: begin
          idx_i <= '0; idx_j <= '0;
          state <= sts.need_search ? S_CLR : S_OUT;
        end
        S_CLR: begin
          idx_j <= idx_j + 1'b1; state <= S_CMP;
        end
        S_CMP: begin
          if (idx_j == Last) state <= S_LAND;
          else idx_j <= idx_j + 1'b1;
        end
        // last pair of the row is counted here
        S_LAND: state <= S_OEND;
        S_OEND: begin
          last_pend <= (idx_i == Last);
          if (idx_i == Last) state <= S_FIN;
          else begin
            idx_i <= idx_i + 1'b1; idx_j <= '0; state <= S_CLR;
          end
        end
        S_FIN: state <= S_OUT;
        S_OUT: if (out_fire) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    cmd.tick = (state == S_EXEC);
    cmd.clr_search = (state == S_EXEC);
    cmd.cmp_step = cmp_pend;
    cmd.outer_end = (state == S_OEND);
    cmd.finish = (state == S_FIN);
  end
  assign in_rdy = (state == S_IDLE);
  assign out_vld = (state == S_OUT);

  a_fin: assert property (@(posedge clk) disable iff (rst) state == S_FIN |-> last_pend)
    else $error("finish without full sweep");
  a_out: assert property (@(posedge clk) disable iff (rst) out_vld && !out_fire |=> out_vld)
    else $error("result dropped");
  a_in: assert property (@(posedge clk) disable iff (rst) in_fire |=> state == S_EXEC)
    else $error("item not executed");
endmodule

FILE: sv/ir_remote_learning_controller_unit.sv
// Top level of the IR remote learning controller.
// Depends on irlc_pkg, irlc_ctrl, irlc_datapath.
`timescale 1ns / 1ps
// One input transaction is one tick; one result follows. A tick passes through accept,
// update and result offered, except the tick that stores the last repeat sample: the
// most-frequent search then compares all 20x20 sample pairs through one comparator
// fed from a two-port sample memory.
// The next item is accepted once the result has been taken.
module ir_remote_learning_controller_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // button_pressed, ir_valid, ir_code[31:0], encoder_delta[7:0], zero fill
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // volume_level, input_select, muted_flag, relay_bits, learn_step,
  // samples_collected, learning_done, zero fill
  output logic [31:0] m_tdata
);
  irlc_pkg::irlc_cmd_t cmd;
  irlc_pkg::irlc_sts_t sts;
  logic [irlc_pkg::SampleIdxW-1:0] idx_i, idx_j;
  logic [41:0] item;
  logic [25:0] result;
  logic in_fire;
  assign in_fire = s_tvalid && s_tready;
  always_ff @(posedge clk) if (in_fire) item <= s_tdata[41:0];

  irlc_ctrl u_ctrl (.clk, .rst, .in_fire, .out_fire(m_tvalid && m_tready), .sts, .cmd,
                    .in_rdy(s_tready), .out_vld(m_tvalid), .idx_i, .idx_j);
  irlc_datapath u_dp (.clk, .rst, .cfg_we, .cfg_index, .cfg_data, .item, .cmd,
                      .idx_i, .idx_j, .sts, .result);
  assign m_tdata = {6'd0, result};
endmodule
